[src/rch_pkg.sv]
// shared types and constants for the range-or-category histogram
// token carried along the cell chain, broadcast command and update records
// no dependencies
package rch_pkg;

	localparam int HIT_W    = 8;   // index width carried in records, covers up to 256 cells
	localparam int SUM_W    = 40;  // width of counter reads and counter sums
	localparam int CNT_BITS = 32;  // bucket counter width
	localparam int WEIGHT_W = 16;
	localparam int ACC_W    = 64;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_WRITE = 3'd1,
		OP_CLEAR = 3'd2,
		OP_READ  = 3'd3,
		OP_SUM   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef enum logic {
		REG_MODE  = 1'b0,
		REG_COUNT = 1'b1
	} reg_index_t;

	// travels one cell per cycle
	typedef struct packed {
		logic             valid;
		logic             prev_ge;   // sample >= boundary of the previous cell
		logic             found;
		logic [HIT_W-1:0] hit;
		logic             lt_first;  // sample below the first boundary
		logic             gt_last;   // sample above the last active boundary
		logic             eq_last;   // sample equal to the last active boundary
		logic             started;   // positive-only sum has reached a positive boundary
		logic [SUM_W-1:0] sum;
	} token_t;

	// held steady for the whole walk
	typedef struct packed {
		logic             category;
		logic             only_pos;
		opcode_t          op;
		logic [HIT_W-1:0] index;
	} cmd_t;

	// single-cycle writes into the cells
	typedef struct packed {
		logic                clear;
		logic                bnd_we;
		logic                cnt_we;
		logic [HIT_W-1:0]    index;
		logic [WEIGHT_W-1:0] weight;
	} upd_t;

endpackage

[src/rch_cell.sv]
// one histogram cell: a boundary entry, its bucket counter and a token stage
// uses rch_pkg
module rch_cell import rch_pkg::*; #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int CNT_W        = 5,
	parameter int CELL_INDEX   = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  upd_t                           upd,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] boundary_value,
	input  logic        [CNT_W-1:0]        n_active,
	input  token_t                         tok_in,
	output token_t                         tok_out
);

	localparam logic [HIT_W-1:0] MY_IDX   = HIT_W'(CELL_INDEX);
	localparam logic [HIT_W-1:0] PREV_IDX = HIT_W'((CELL_INDEX > 0) ? CELL_INDEX - 1 : 0);
	localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(CELL_INDEX);

	logic signed [SAMPLE_WIDTH-1:0] bnd_q;
	logic signed [CNT_BITS-1:0]     cnt_q;
	token_t                         token_q;
	token_t                         nxt;

	logic             lt, eq, gt, pos, active, is_last, started_n;
	logic [SUM_W-1:0] cnt_ext;

	always_comb begin
		lt        = sample < bnd_q;
		eq        = sample == bnd_q;
		gt        = bnd_q < sample;
		pos       = !bnd_q[SAMPLE_WIDTH-1] && (bnd_q != '0);
		active    = MY_POS < n_active;
		is_last   = MY_POS == (n_active - CNT_W'(1));
		cnt_ext   = SUM_W'(cnt_q);
		started_n = tok_in.started || pos;
		nxt       = tok_in;
		if (active) begin
			case (cmd.op)
				OP_ADD: begin
					if (cmd.category) begin
						if (eq && !tok_in.found) begin
							nxt.found = 1'b1;
							nxt.hit   = MY_IDX;
						end
					end else begin
						// bucket of the previous cell closes at this boundary
						if (CELL_INDEX > 0 && tok_in.prev_ge && lt && !tok_in.found) begin
							nxt.found = 1'b1;
							nxt.hit   = PREV_IDX;
						end
						nxt.prev_ge = !lt;
						if (CELL_INDEX == 0) begin
							nxt.lt_first = lt;
						end
						if (is_last) begin
							nxt.gt_last = gt;
							nxt.eq_last = eq;
						end
					end
				end
				OP_READ: begin
					if (cmd.index == MY_IDX) begin
						nxt.sum = cnt_ext;
					end
				end
				OP_SUM: begin
					nxt.started = started_n;
					if (!cmd.only_pos || started_n) begin
						nxt.sum = tok_in.sum + cnt_ext;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else begin
			token_q <= nxt;
		end
	end

	// boundary entries are undefined until written
	always_ff @(posedge clk) begin
		if (upd.bnd_we && upd.index == MY_IDX) begin
			bnd_q <= boundary_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd.clear) begin
			cnt_q <= '0;
		end else if (upd.cnt_we && upd.index == MY_IDX) begin
			cnt_q <= cnt_q + CNT_BITS'($signed(upd.weight));
		end
	end

	assign tok_out = token_q;

endmodule

[src/range_or_category_histogram_top.sv]
// top level of the range-or-category histogram: apb registers, control fsm,
// the row of histogram cells and the result register; uses rch_pkg and rch_cell
//
// A row of MAX_BOUNDARIES identical cells holds the boundary table and the bucket
// counters, one entry per cell. Add, read-counter and sum transactions send a token
// down the row, one cell per clock; each cell compares the sample with its boundary
// (range or category mode), picks out its counter, or adds it into the running sum.
// When the token leaves the last cell the result is formed, the chosen counter and
// the 64-bit accumulator are updated, and the result goes to the output register.
// Such a transaction holds the block until its token has crossed the whole cell row;
// write-boundary, clear and unknown opcodes go straight to the commit state and
// skip the walk. A new transaction is taken while the previous result still waits
// on the output; it completes once that result has been taken.
// category_mode sits at address 0, boundary_count at address 4; a boundary_count
// below 2 acts as 2 and one above MAX_BOUNDARIES acts as MAX_BOUNDARIES. There is
// no clearing pass after reset: counters and accumulator reset directly, and the
// boundary table holds nothing defined until written.
module range_or_category_histogram_top import rch_pkg::*; #(
	parameter int MAX_BOUNDARIES = 16,
	parameter int SAMPLE_WIDTH   = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	// configuration port
	input  logic                                              psel,
	input  logic                                              penable,
	input  logic                                              pwrite,
	input  logic [2:0]                                        paddr,
	input  logic [31:0]                                       pwdata,
	output logic [31:0]                                       prdata,
	output logic                                              pready,
	// item channel
	input  logic                                              item_valid,
	output logic                                              item_ready,
	input  logic [2:0]                                        opcode,
	input  logic signed [SAMPLE_WIDTH-1:0]                    sample,
	input  logic signed [WEIGHT_W-1:0]                        weight,
	input  logic [((MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1)-1:0] entry_index,
	input  logic signed [SAMPLE_WIDTH-1:0]                    boundary_value,
	input  logic                                              only_positive,
	// result channel
	output logic                                              result_valid,
	input  logic                                              result_ready,
	output logic                                              miss,
	output logic [((MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1)-1:0] bucket_hit,
	output logic signed [SUM_W-1:0]                           count_value,
	output logic signed [ACC_W-1:0]                           accumulated
);

	localparam int IDX_W    = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
	localparam int CNT_W    = $clog2(MAX_BOUNDARIES + 1);
	localparam int PROD_W   = SAMPLE_WIDTH + WEIGHT_W;
	localparam int BC_RESET = (MAX_BOUNDARIES < 16) ? MAX_BOUNDARIES : 16;

	// configuration registers
	logic             category_q;
	logic [CNT_W-1:0] bcount_q;
	logic [CNT_W-1:0] n_eff;
	logic             cfg_we;

	// transaction held for the duration of its walk
	state_t                         state_q, state_n;
	opcode_t                        op_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] bval_q;
	logic [WEIGHT_W-1:0]            weight_q;
	logic [IDX_W-1:0]               idx_q;
	logic                           only_pos_q;
	logic [ACC_W-1:0]               product_q;
	logic signed [PROD_W-1:0]       prod_full;

	logic [ACC_W-1:0] acc_q, acc_next;
	token_t           tail_q;
	logic             launch, fire, accept, walk_op;

	// result register
	logic             out_valid_q;
	logic             miss_q;
	logic [IDX_W-1:0] hit_q;
	logic [SUM_W-1:0] count_q;
	logic [ACC_W-1:0] acc_out_q;

	logic             res_miss, hit_ok;
	logic [HIT_W-1:0] res_hit, k_sel;
	logic [SUM_W-1:0] res_count;

	cmd_t   cmd;
	upd_t   upd;
	token_t tok_chain [0:MAX_BOUNDARIES];
	logic [MAX_BOUNDARIES-1:0] chain_valid;

	// ---------------------------------------------------------------- apb
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			category_q <= 1'b0;
			bcount_q   <= CNT_W'(BC_RESET);
		end else if (cfg_we) begin
			case (reg_index_t'(paddr[2]))
				REG_MODE:  category_q <= pwdata[0];
				REG_COUNT: bcount_q   <= pwdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index_t'(paddr[2]))
			REG_MODE:  prdata = 32'(category_q);
			REG_COUNT: prdata = 32'(bcount_q);
			default:   prdata = '0;
		endcase
	end

	// active boundary count, clamped to the table
	always_comb begin
		if (bcount_q < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (bcount_q > CNT_W'(MAX_BOUNDARIES)) begin
			n_eff = CNT_W'(MAX_BOUNDARIES);
		end else begin
			n_eff = bcount_q;
		end
	end

	// ---------------------------------------------------------------- control fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		item_ready = 1'b0;
		launch     = 1'b0;
		fire       = 1'b0;
		walk_op    = (opcode_t'(opcode) == OP_ADD) || (opcode_t'(opcode) == OP_READ) ||
			(opcode_t'(opcode) == OP_SUM);
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_n = walk_op ? ST_LAUNCH : ST_FINISH;
				end
			end
			ST_LAUNCH: begin
				launch  = 1'b1;
				state_n = ST_WALK;
			end
			ST_WALK: begin
				if (tok_chain[MAX_BOUNDARIES].valid) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// commit only when the result register can take the outcome
				fire = !out_valid_q || result_ready;
				if (fire) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign accept    = item_valid && item_ready;
	assign prod_full = PROD_W'(sample) * PROD_W'(weight);

	// transaction capture, product registered before it reaches the accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode_t'(opcode);
			sample_q   <= sample;
			bval_q     <= boundary_value;
			weight_q   <= weight;
			idx_q      <= entry_index;
			only_pos_q <= only_positive;
			product_q  <= ACC_W'(prod_full);
		end
	end

	// token leaving the last cell
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && tok_chain[MAX_BOUNDARIES].valid) begin
			tail_q <= tok_chain[MAX_BOUNDARIES];
		end
	end

	// ---------------------------------------------------------------- cell row
	always_comb begin
		tok_chain[0]       = '0;
		tok_chain[0].valid = launch;
	end

	always_comb begin
		cmd.category = category_q;
		cmd.only_pos = only_pos_q;
		cmd.op       = op_q;
		cmd.index    = HIT_W'(idx_q);
	end

	for (genvar g = 0; g < MAX_BOUNDARIES; g++) begin : g_cell
		rch_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.CNT_W       (CNT_W),
			.CELL_INDEX  (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.upd           (upd),
			.sample        (sample_q),
			.boundary_value(bval_q),
			.n_active      (n_eff),
			.tok_in        (tok_chain[g]),
			.tok_out       (tok_chain[g+1])
		);
		assign chain_valid[g] = tok_chain[g+1].valid;
	end

	// ---------------------------------------------------------------- result and commit
	always_comb begin
		res_miss   = 1'b0;
		res_hit    = '0;
		res_count  = '0;
		acc_next   = acc_q;
		hit_ok     = 1'b0;
		k_sel      = '0;
		upd.clear  = 1'b0;
		upd.bnd_we = 1'b0;
		upd.cnt_we = 1'b0;
		upd.index  = HIT_W'(idx_q);
		upd.weight = weight_q;
		case (op_q)
			OP_ADD: begin
				if (category_q) begin
					hit_ok = tail_q.found;
					k_sel  = tail_q.hit;
				end else begin
					// inside [first, last]; the last boundary itself falls in bucket n-2
					hit_ok = !tail_q.lt_first && !tail_q.gt_last &&
						(tail_q.found || tail_q.eq_last);
					k_sel  = tail_q.found ? tail_q.hit : HIT_W'(n_eff - CNT_W'(2));
				end
				res_miss = !hit_ok;
				if (hit_ok) begin
					res_hit    = k_sel;
					acc_next   = acc_q + product_q;
					upd.cnt_we = fire;
					upd.index  = k_sel;
				end
			end
			OP_WRITE: begin
				upd.bnd_we = fire;
			end
			OP_CLEAR: begin
				upd.clear = fire;
				acc_next  = '0;
			end
			OP_READ: begin
				if (CNT_W'(idx_q) >= n_eff) begin
					res_miss = 1'b1;
				end else begin
					res_count = tail_q.sum;
				end
			end
			OP_SUM: begin
				res_count = tail_q.sum;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q       <= acc_next;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			miss_q    <= res_miss;
			hit_q     <= res_hit[IDX_W-1:0];
			count_q   <= res_count;
			acc_out_q <= acc_next;
		end
	end

	assign result_valid = out_valid_q;
	assign miss         = miss_q;
	assign bucket_hit   = hit_q;
	assign count_value  = count_q;
	assign accumulated  = acc_out_q;

	// ---------------------------------------------------------------- assertions
	// a single token is ever in flight along the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_valid) <= 1)
		else $error("more than one token in the cell row");

	// the token only leaves the row while the fsm is waiting for it
	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_chain[MAX_BOUNDARIES].valid |-> state_q == ST_WALK)
		else $error("token left the row outside the walk");

	// a counter update never lands beyond the active boundaries
	a_update_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		upd.cnt_we |-> CNT_W'(upd.index) < n_eff)
		else $error("counter update outside active buckets");

	// a committed clear reports and holds a zero accumulator
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		upd.clear |=> (acc_q == '0) && (acc_out_q == '0))
		else $error("accumulator not zero after clear");

endmodule

[sim/range_or_category_histogram_top_test.sv]
// self-checking bench for range_or_category_histogram_top: boundary table, counters, sums
// depends on rch_pkg and the histogram rtl only; no files, no arguments
module range_or_category_histogram_top_test import rch_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BND        = 16;
	localparam int RESET_CYCLES   = 9;
	localparam int ITEM_TARGET    = 1850;
	localparam int SETTLE_CYCLES  = 25;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int PRINT_CAP      = 100;

	// opcodes the block treats as no-ops
	localparam logic [2:0] OP_FIRST_UNKNOWN = 3'd5;
	localparam logic [2:0] OP_LAST_UNKNOWN  = 3'd7;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [15:0] W_MIN   = 16'sh8000;
	localparam logic signed [15:0] W_MAX   = 16'sh7fff;

	// one item transaction as the bench sees it
	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] smp;
		logic signed [15:0] wgt;
		logic [3:0]         idx;
		logic signed [31:0] bval;
		logic               pos_only;
	} hist_op_t;

	// one result transaction
	typedef struct packed {
		logic               missed;
		logic [3:0]         bucket;
		logic signed [39:0] count;
		logic signed [63:0] acc;
	} hist_result_t;

	// clock, reset and dut ports
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	logic     item_valid = 1'b0;
	logic     item_ready;
	hist_op_t cur_op     = '0;

	logic [2:0]         opcode;
	logic signed [31:0] sample;
	logic signed [15:0] weight;
	logic [3:0]         entry_index;
	logic signed [31:0] boundary_value;
	logic               only_positive;

	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               miss;
	logic [3:0]         bucket_hit;
	logic signed [39:0] count_value;
	logic signed [63:0] accumulated;

	// the held transaction fans out to one port per field
	assign opcode         = cur_op.op;
	assign sample         = cur_op.smp;
	assign weight         = cur_op.wgt;
	assign entry_index    = cur_op.idx;
	assign boundary_value = cur_op.bval;
	assign only_positive  = cur_op.pos_only;

	range_or_category_histogram_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.opcode        (opcode),
		.sample        (sample),
		.weight        (weight),
		.entry_index   (entry_index),
		.boundary_value(boundary_value),
		.only_positive (only_positive),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.miss          (miss),
		.bucket_hit    (bucket_hit),
		.count_value   (count_value),
		.accumulated   (accumulated)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// histogram shadow: boundary table, bucket counters, accumulator, registers
	logic signed [31:0] bound_tab [MAX_BND];
	logic signed [31:0] bin_count [MAX_BND];
	logic signed [63:0] acc_total = '0;
	logic               mode_cat  = 1'b0;
	logic [4:0]         count_reg = 5'd16;

	// stimulus side: what the table will hold once queued writes land
	logic signed [31:0] plan_tab [MAX_BND];
	int                 gen_n = MAX_BND;

	hist_op_t     queued_ops [$];     // transactions not yet offered
	hist_result_t owed_results [$];   // results the block still owes, oldest first

	int err_count    = 0;
	int results_seen = 0;
	int ops_issued   = 0;
	int cycle_count  = 0;
	int hold_left    = 0;
	int stall_left   = 0;
	bit drv_calm     = 1'b0;
	bit mon_calm     = 1'b0;

	// scratch for the stimulus process
	hist_op_t           o;
	int                 i, j, k, kind, burst;
	logic signed [31:0] lo, hi, tmp;
	logic [31:0]        span;
	logic               mode_pick;
	logic [4:0]         count_pick;

	initial begin
		for (i = 0; i < MAX_BND; i++) begin
			bound_tab[i] = '0;
			bin_count[i] = '0;
			plan_tab[i]  = '0;
		end
	end

	// works out the result of one transaction and advances the shadow state
	function automatic hist_result_t apply_histogram_op(input hist_op_t op_in);
		hist_result_t       r;
		int                 n;
		int                 b;
		int                 e;
		logic signed [31:0] smp;
		logic signed [31:0] w32;
		logic signed [63:0] s64;
		logic signed [63:0] w64;
		logic signed [39:0] total;
		r     = '0;
		smp   = op_in.smp;
		w32   = 32'(op_in.wgt);
		s64   = 64'(op_in.smp);
		w64   = 64'(op_in.wgt);
		total = '0;
		b     = -1;
		// register value is clamped into 2..16
		n = (count_reg < 2) ? 2 : ((count_reg > MAX_BND) ? MAX_BND : int'(count_reg));
		case (op_in.op)
			OP_ADD: begin
				if (mode_cat) begin
					// first equal entry wins
					for (e = n - 1; e >= 0; e--)
						if (bound_tab[e] == smp)
							b = e;
				end else if (smp >= bound_tab[0] && smp <= bound_tab[n - 1]) begin
					for (e = n - 2; e >= 0; e--)
						if (smp >= bound_tab[e] && smp < bound_tab[e + 1])
							b = e;
					// top boundary belongs to the last bucket
					if (b < 0 && smp == bound_tab[n - 1])
						b = n - 2;
				end
				if (b < 0) begin
					r.missed = 1'b1;
				end else begin
					bin_count[b] = bin_count[b] + w32;
					acc_total    = acc_total + s64 * w64;
					r.bucket     = 4'(b);
				end
			end
			OP_WRITE: bound_tab[op_in.idx] = op_in.bval;
			OP_CLEAR: begin
				for (e = 0; e < MAX_BND; e++)
					bin_count[e] = '0;
				acc_total = '0;
			end
			OP_READ: begin
				if (op_in.idx >= n) begin
					r.missed = 1'b1;
				end else begin
					total   = 40'(bin_count[op_in.idx]);
					r.count = total;
				end
			end
			OP_SUM: begin
				e = 0;
				if (op_in.pos_only)
					while (e < n && !(bound_tab[e] > 0))
						e++;
				for (; e < n; e++)
					total = total + 40'(bin_count[e]);
				r.count = total;
			end
			default: ;
		endcase
		r.acc = acc_total;
		return r;
	endfunction

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// every field random, opcode fixed
	function automatic hist_op_t any_op(input logic [2:0] op);
		hist_op_t t;
		t.op       = op;
		t.smp      = $urandom;
		t.wgt      = 16'($urandom);
		t.idx      = 4'($urandom);
		t.bval     = $urandom;
		t.pos_only = 1'($urandom);
		return t;
	endfunction

	task automatic issue(input hist_op_t t);
		queued_ops.push_back(t);
		ops_issued++;
		if (t.op == OP_WRITE)
			plan_tab[t.idx] = t.bval;
	endtask

	// queue a write of every table entry from plan_tab
	task automatic load_table();
		hist_op_t t;
		for (int e = 0; e < MAX_BND; e++) begin
			t      = any_op(OP_WRITE);
			t.idx  = 4'(e);
			t.bval = plan_tab[e];
			issue(t);
		end
	endtask

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
	endtask

	// wait until every transaction is offered, taken and answered, then let the block settle
	task automatic wait_drained();
		while (queued_ops.size() != 0 || item_valid || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, register lands when pready is seen
	task automatic reg_write(input reg_index_t which, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (which)
			REG_MODE:  mode_cat  = value[0];
			REG_COUNT: count_reg = value[4:0];
			default: ;
		endcase
	endtask

	// registers change only with the block idle
	task automatic set_config(input logic mode, input logic [4:0] count);
		wait_drained();
		reg_write(REG_MODE, {31'd0, mode});
		reg_write(REG_COUNT, {27'd0, count});
		gen_n = (count < 2) ? 2 : ((count > MAX_BND) ? MAX_BND : int'(count));
	endtask

	// item driver: holds each transaction until taken, random gap before the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				owed_results.push_back(apply_histogram_op(cur_op));
			if (!item_valid || item_ready) begin
				if (hold_left > 0) begin
					hold_left--;
					item_valid <= 1'b0;
				end else if (queued_ops.size() > 0) begin
					cur_op     <= queued_ops.pop_front();
					item_valid <= 1'b1;
					// occasional stretches with back-to-back transactions
					if ($urandom_range(0, 39) == 0)
						drv_calm = !drv_calm;
					hold_left = draw_wait(drv_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest owed result, random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					report_mismatch("result with nothing outstanding");
				end else begin
					if (miss !== owed_results[0].missed)
						report_mismatch($sformatf("miss %b, expected %b",
							miss, owed_results[0].missed));
					if (bucket_hit !== owed_results[0].bucket)
						report_mismatch($sformatf("bucket_hit %0d, expected %0d",
							bucket_hit, owed_results[0].bucket));
					if (count_value !== owed_results[0].count)
						report_mismatch($sformatf("count_value %0d, expected %0d",
							count_value, owed_results[0].count));
					if (accumulated !== owed_results[0].acc)
						report_mismatch($sformatf("accumulated %0d, expected %0d",
							accumulated, owed_results[0].acc));
					void'(owed_results.pop_front());
				end
				if ($urandom_range(0, 39) == 0)
					mon_calm = !mon_calm;
				stall_left = draw_wait(mon_calm);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_ready <= (stall_left == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("range_or_category_histogram_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// sorted range table spanning the full sample range
		set_config(1'b0, 5'd16);
		plan_tab = '{S32_MIN, -1000000, -5000, -100, -1, 0, 1, 7, 100, 1000, 65536,
			1000000, 100000000, 1000000000, 2000000000, S32_MAX};
		load_table();

		// lowest sample into the first bucket, largest weight
		o = any_op(OP_ADD); o.smp = S32_MIN; o.wgt = W_MAX; issue(o);
		// top boundary itself is inclusive
		o = any_op(OP_ADD); o.smp = S32_MAX; o.wgt = W_MIN; issue(o);
		o = any_op(OP_ADD); o.smp = 0; o.wgt = 16'sd1; issue(o);
		o = any_op(OP_ADD); o.smp = -1; o.wgt = -16'sd1; issue(o);
		o = any_op(OP_ADD); o.smp = S32_MAX - 1; o.wgt = 16'sd1; issue(o);
		o = any_op(OP_READ); o.idx = 4'd0; issue(o);
		o = any_op(OP_READ); o.idx = 4'd14; issue(o);
		o = any_op(OP_READ); o.idx = 4'd15; issue(o);
		o = any_op(OP_SUM); o.pos_only = 1'b0; issue(o);
		o = any_op(OP_SUM); o.pos_only = 1'b1; issue(o);
		issue(any_op(OP_FIRST_UNKNOWN));
		issue(any_op(OP_LAST_UNKNOWN));
		issue(any_op(OP_CLEAR));
		o = any_op(OP_READ); o.idx = 4'd0; issue(o);
		o = any_op(OP_SUM); o.pos_only = 1'b0; issue(o);

		// four boundaries, all negative
		set_config(1'b0, 5'd4);
		o = any_op(OP_ADD); o.smp = 0; issue(o);          // above the last boundary
		o = any_op(OP_ADD); o.smp = -100; issue(o);       // equal to the last boundary
		o = any_op(OP_READ); o.idx = 4'd4; issue(o);      // index past the active count
		o = any_op(OP_SUM); o.pos_only = 1'b1; issue(o);  // no positive boundary

		// register below the minimum acts as two boundaries
		set_config(1'b0, 5'd0);
		o = any_op(OP_ADD); o.smp = -1000000; issue(o);
		o = any_op(OP_READ); o.idx = 4'd2; issue(o);

		// category mode with a duplicated entry, register above the maximum
		set_config(1'b1, 5'd31);
		o = any_op(OP_WRITE); o.idx = 4'd3; o.bval = 42; issue(o);
		o = any_op(OP_WRITE); o.idx = 4'd9; o.bval = 42; issue(o);
		o = any_op(OP_ADD); o.smp = 42; issue(o);
		o = any_op(OP_ADD); o.smp = 43; issue(o);
		o = any_op(OP_ADD); o.smp = S32_MAX; issue(o);
		o = any_op(OP_SUM); o.pos_only = 1'b1; issue(o);

		// random phases: new registers, often a fresh table, then a mix of transactions
		while (ops_issued < ITEM_TARGET) begin
			mode_pick = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1, 2: count_pick = 5'd16;
				3:       count_pick = 5'd2;
				4:       count_pick = 5'($urandom_range(0, 1));
				5:       count_pick = 5'($urandom_range(17, 31));
				default: count_pick = 5'($urandom_range(3, 15));
			endcase
			set_config(mode_pick, count_pick);

			if ($urandom_range(0, 2) != 0) begin
				// wide, narrow with repeats, medium with extremes, or unsorted
				kind = $urandom_range(0, 3);
				for (i = 0; i < MAX_BND; i++)
					case (kind)
						0:       plan_tab[i] = $urandom;
						1, 3:    plan_tab[i] = $urandom_range(0, 40) - 20;
						default: plan_tab[i] = $urandom_range(0, 4000) - 2000;
					endcase
				if (kind != 3)
					for (i = 0; i < MAX_BND - 1; i++)
						for (j = 0; j < MAX_BND - 1 - i; j++)
							if (plan_tab[j] > plan_tab[j + 1]) begin
								tmp             = plan_tab[j];
								plan_tab[j]     = plan_tab[j + 1];
								plan_tab[j + 1] = tmp;
							end
				if (kind == 2) begin
					plan_tab[0] = S32_MIN;
					for (i = gen_n - 1; i < MAX_BND; i++)
						plan_tab[i] = S32_MAX;
				end
				load_table();
			end

			// keep the total close to the target
			burst = $urandom_range(150, 300);
			if (burst > ITEM_TARGET - ops_issued)
				burst = ITEM_TARGET - ops_issued;
			repeat (burst) begin
				k = $urandom_range(0, 99);
				if (k < 55) begin
					o = any_op(OP_ADD);
					// samples mostly on or next to boundaries, or between the end boundaries
					k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_BND - 1)
						: $urandom_range(0, gen_n - 1);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: o.smp = plan_tab[k];
						4, 5: o.smp = ($urandom_range(0, 1) != 0) ? plan_tab[k] + 1
							: plan_tab[k] - 1;
						6, 7: begin
							lo    = (plan_tab[0] < plan_tab[gen_n - 1]) ? plan_tab[0]
								: plan_tab[gen_n - 1];
							hi    = (plan_tab[0] < plan_tab[gen_n - 1]) ? plan_tab[gen_n - 1]
								: plan_tab[0];
							span  = hi - lo;
							o.smp = lo + $urandom_range(span, 0);
						end
						default: ;
					endcase
					case ($urandom_range(0, 9))
						0, 1:    o.wgt = 16'sd1;
						2:       o.wgt = W_MIN;
						3:       o.wgt = W_MAX;
						default: ;
					endcase
				end else if (k < 63) begin
					// mostly small nudges so a sorted table stays close to sorted
					o = any_op(OP_WRITE);
					if ($urandom_range(0, 4) != 0)
						o.bval = plan_tab[o.idx] + $urandom_range(0, 6) - 3;
				end else if (k < 67) begin
					o = any_op(OP_CLEAR);
				end else if (k < 80) begin
					o = any_op(OP_READ);
					if ($urandom_range(0, 1) != 0)
						o.idx = 4'($urandom_range(0, gen_n - 1));
				end else if (k < 93) begin
					o = any_op(OP_SUM);
				end else begin
					o = any_op(3'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN)));
				end
				issue(o);
			end
		end

		wait_drained();
		if (err_count == 0)
			$display("range_or_category_histogram_top verification clean");
		else
			$display("range_or_category_histogram_top verification failed");
		$finish;
	end

endmodule

[range_or_category_histogram_top.f]
src/rch_pkg.sv
src/rch_cell.sv
src/range_or_category_histogram_top.sv
sim/range_or_category_histogram_top_test.sv
